// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_FIELD_W = 16;
  localparam int INDEX_W       = 4;
  localparam int COUNT_W       = 5;
  localparam int MIN_VERTICES  = 3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;       // write one vertex word into the store
    logic load_point;  // capture the query point, clear the parity flag
    logic rd_en;       // read one vertex from the store
    logic rd_first;    // this read only primes the previous-vertex register
  } pip_cmd_t;

endpackage

// ===== rtl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pip_ctrl
// Controller: takes commands, holds the vertex count, sequences the edge walk.
// ----------------------------------------------------------------------------
module pip_ctrl import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic                            cfg_we_i,
  input  logic [COUNT_W-1:0]              cfg_wdata_i,
  output pip_cmd_t                        cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_addr_o,
  output logic                            done_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] count_q;
  logic [CW-1:0]      n_run_q;
  logic [CW-1:0]      cnt_q;
  logic               valid_q;

  logic [NW-1:0] count_ext;
  logic [CW-1:0] n_cfg;
  logic [CW-1:0] addr_full;
  logic          accept;
  logic          query;

  // Clamp the count to the store size
  assign count_ext = NW'(count_q);
  assign n_cfg     = (count_ext > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : count_ext[CW-1:0];

  assign accept = start_i && (state_q == S_IDLE);
  assign query  = accept && (func_i == FUNC_QUERY);

  // First read fetches the last vertex in use, then vertices 0 .. n-1
  assign addr_full = (cnt_q == '0) ? (n_run_q - CW'(1)) : (cnt_q - CW'(1));

  assign cmd_o.wr_en      = accept && (func_i == FUNC_WRITE);
  assign cmd_o.load_point = query;
  assign cmd_o.rd_en      = (state_q == S_ISSUE);
  assign cmd_o.rd_first   = (cnt_q == '0);
  assign rd_addr_o        = addr_full[AW-1:0];

  assign busy_o = (state_q != S_IDLE);
  assign done_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      n_run_q <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (query) begin
            n_run_q <= n_cfg;
            cnt_q   <= '0;
            if (n_cfg < CW'(MIN_VERTICES)) begin
              // too few vertices: answer outside right away
              valid_q <= 1'b1;
            end else begin
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (cnt_q == n_run_q) begin
            state_q <= S_DRAIN1;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_DRAIN1: begin
          state_q <= S_DRAIN2;
        end
        S_DRAIN2: begin
          state_q <= S_IDLE;
          valid_q <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_short_poly_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query && (n_cfg < CW'(MIN_VERTICES))) |=> (done_o && !busy_o))
    else $error("short polygon query did not answer in one cycle");

  a_walk_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query && (n_cfg >= CW'(MIN_VERTICES))) |=> (busy_o && cmd_o.rd_en && cmd_o.rd_first))
    else $error("edge walk did not start after query");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (cnt_q <= n_run_q))
    else $error("edge counter ran past the vertex count");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN2) |=> (done_o && !busy_o))
    else $error("result strobe missing after drain");
`endif

endmodule

// ===== rtl/pip_dpath.sv =====
// ----------------------------------------------------------------------------
// pip_dpath
// Datapath: vertex store, edge crossing products and even-odd parity flag.
// ----------------------------------------------------------------------------
module pip_dpath import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pip_cmd_t                        cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr_i,
  input  logic [INDEX_W-1:0]              vertex_index_i,
  input  logic signed [COORD_FIELD_W-1:0] x_coord_i,
  input  logic signed [COORD_FIELD_W-1:0] y_coord_i,
  output logic                            inside_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int FW = (COORD_WIDTH > COORD_FIELD_W) ? COORD_WIDTH : COORD_FIELD_W;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // Input coordinates: low COORD_WIDTH bits of the field, sign from the top one
  logic [IW-1:0]                 idx_ext;
  logic                          idx_ok;
  logic [FW-1:0]                 x_ext;
  logic [FW-1:0]                 y_ext;
  logic signed [COORD_WIDTH-1:0] x_cv;
  logic signed [COORD_WIDTH-1:0] y_cv;

  assign idx_ext = IW'(vertex_index_i);
  assign idx_ok  = (idx_ext < IW'(MAX_VERTICES));
  assign x_ext   = FW'($unsigned(x_coord_i));
  assign y_ext   = FW'($unsigned(y_coord_i));
  assign x_cv    = x_ext[COORD_WIDTH-1:0];
  assign y_cv    = y_ext[COORD_WIDTH-1:0];

  logic [2*COORD_WIDTH-1:0] rdata;

  pip_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en && idx_ok),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i ({x_cv, y_cv}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic                          s1_vld_q, s1_first_q;
  logic                          s2_vld_q, s2_cross_q, s2_up_q;
  logic signed [PW-1:0]          prod_l_q, prod_r_q;
  logic                          acc_q;

  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic signed [DW-1:0]          diff_a, diff_b, diff_c, diff_d;
  logic signed [PW-1:0]          prod_l_d, prod_r_d;
  logic                          cross_d, up_d, hit;

  assign cur_x = rdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign cur_y = rdata[COORD_WIDTH-1:0];

  // Edge from current vertex i to previous vertex j
  assign diff_a   = DW'(px_q) - DW'(cur_x);
  assign diff_b   = DW'(prev_y_q) - DW'(cur_y);
  assign diff_c   = DW'(prev_x_q) - DW'(cur_x);
  assign diff_d   = DW'(py_q) - DW'(cur_y);
  assign prod_l_d = PW'(diff_a) * PW'(diff_b);
  assign prod_r_d = PW'(diff_c) * PW'(diff_d);
  assign cross_d  = (cur_y > py_q) != (prev_y_q > py_q);
  assign up_d     = (prev_y_q > cur_y);

  // Compare sides by the direction of the edge in y
  assign hit = s2_cross_q && (s2_up_q ? (prod_l_q < prod_r_q) : (prod_r_q < prod_l_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      acc_q      <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.rd_first;
      s2_vld_q   <= s1_vld_q && !s1_first_q;
      if (cmd_i.load_point) begin
        acc_q <= 1'b0;
      end else if (s2_vld_q) begin
        acc_q <= acc_q ^ hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      px_q <= x_cv;
      py_q <= y_cv;
    end
    if (s1_vld_q) begin
      prev_x_q   <= cur_x;
      prev_y_q   <= cur_y;
      prod_l_q   <= prod_l_d;
      prod_r_q   <= prod_r_d;
      s2_cross_q <= cross_d;
      s2_up_q    <= up_d;
    end
  end

  assign inside_o = acc_q;

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-casting point-in-polygon test over a stored vertex list.
// ----------------------------------------------------------------------------
// Usage: drive func_i, vertex_index_i, x_coord_i and y_coord_i and raise
// start_i; the word is taken at a rising edge with start_i high and busy_o low.
// A vertex write (func 0) is stored at that edge and gives no
// result; slots at or beyond MAX_VERTICES are dropped. A query (func 1) gives
// one result word: inside_res_o, valid for exactly the one cycle in which
// done_o is high. The receiver cannot stall; it must take the word then.
// With n vertices in use (vertex_count clamped to MAX_VERTICES), a query
// with n >= 3 shows done_o after the edge walk: the walk reads one vertex
// per cycle from the single read port of the vertex store (n + 1 reads),
// then a product stage and a compare stage drain. busy_o is high over that
// walk, so queries run one at a time. With n < 3 done_o comes in the next
// cycle with inside_res_o low and busy_o never rises.
// The user sets vertex_count (cfg_we_i, cfg_wdata_i) while idle; not enforced.
// Reset clears the count to zero and the control state; the vertex store is
// not cleared, so every vertex in use must be written before a query.
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic [INDEX_W-1:0]              vertex_index_i,
  input  logic signed [COORD_FIELD_W-1:0] x_coord_i,
  input  logic signed [COORD_FIELD_W-1:0] y_coord_i,
  input  logic                            cfg_we_i,
  input  logic [COUNT_W-1:0]              cfg_wdata_i,
  output logic                            done_o,
  output logic                            inside_res_o
);

  pip_cmd_t                        cmd;
  logic [$clog2(MAX_VERTICES)-1:0] rd_addr;

  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .done_o      (done_o)
  );

  pip_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .vertex_index_i (vertex_index_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .inside_o       (inside_res_o)
  );

endmodule
